FILE: hw/rtl/cbc_pkg.sv
package cbc_pkg;

   localparam logic [2:0] MODE_CONGRUENCE = 3'd0;
   localparam logic [2:0] MODE_AT_LEAST   = 3'd1;
   localparam logic [2:0] MODE_AT_MOST    = 3'd2;
   localparam logic [2:0] MODE_GREATER    = 3'd3;
   localparam logic [2:0] MODE_LESS       = 3'd4;
   localparam logic [2:0] MODE_EQUAL      = 3'd5;

   localparam logic [2:0] VERDICT_NONE       = 3'd0;
   localparam logic [2:0] VERDICT_CONSISTENT = 3'd1;
   localparam logic [2:0] VERDICT_CLASH      = 3'd2;
   localparam logic [2:0] VERDICT_INFEASIBLE = 3'd3;
   localparam logic [2:0] VERDICT_PINNED     = 3'd4;
   localparam logic [2:0] VERDICT_OVERFLOW   = 3'd5;

   localparam logic [63:0] FIELD_MAX31 = 64'h7FFF_FFFF;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_A2,
      OP_SET_A2,
      OP_FIRST,
      OP_EU_INIT,
      OP_EU_DIV,
      OP_EU_MUL,
      OP_EU_UPD,
      OP_DIV_DIFF,
      OP_SET_CLASH,
      OP_SET_DQ,
      OP_DIV_N1G,
      OP_SET_N1G,
      OP_DIV_M2,
      OP_SET_M2,
      OP_LCM_MUL,
      OP_SET_OVF,
      OP_DIV_D,
      OP_SET_D,
      OP_DIV_INV,
      OP_SET_INV,
      OP_T_MUL,
      OP_DIV_T,
      OP_SET_T,
      OP_T_ZERO,
      OP_R_MUL,
      OP_COMMIT,
      OP_DIV_FIN,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic merge_en;
      logic last;
      logic agg_empty;
      logic r1_zero;
      logic rem_zero;
      logic lcm_over;
      logic m2_one;
      logic need_bound;
      logic out_full;
   } status_type;

endpackage

FILE: hw/rtl/cbc_divider.sv
module cbc_divider
   import cbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [30:0] divisor,
   output logic        busy,
   output logic [63:0] quotient,
   output logic [30:0] remainder
);

   logic [63:0] quo_ff, quo_in;
   logic [30:0] rem_ff, rem_in;
   logic [30:0] dsr_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [31:0] partial;
   logic        take;

   // one quotient bit per cycle, restoring
   always_comb begin
      partial = {rem_ff, quo_ff[63]};
      take    = partial >= {1'b0, dsr_ff};
      rem_in  = take ? 31'(partial - {1'b0, dsr_ff}) : partial[30:0];
      quo_in  = {quo_ff[62:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '1;
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/cbc_datapath.sv
module cbc_datapath
   import cbc_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   input  logic [30:0]        req_modulus,
   input  logic               req_last,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [2:0]         rsp_verdict,
   output logic signed [31:0] rsp_pinned_value,
   output logic [30:0]        rsp_merged_residue,
   output logic [30:0]        rsp_merged_modulus
);

   localparam logic [63:0] LIM_W = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
   localparam logic [63:0] MOD_LIMIT = (LIM_W < FIELD_MAX31) ? LIM_W : FIELD_MAX31;

   logic [30:0]        agg_res_ff, agg_mod_ff;
   logic               clash_ff, ovf_ff;
   logic signed [32:0] low_ff, high_ff;
   logic               low_v_ff, high_v_ff;
   logic signed [31:0] val_ff;
   logic [30:0]        mod_ff;
   logic               last_ff, merge_ff;
   logic [30:0]        a2_ff, r0_ff, r1_ff;
   logic signed [32:0] s0_ff, s1_ff, dq_ff;
   logic [63:0]        prod_ff;
   logic [30:0]        n1g_ff, m2_ff, d_ff, inv_ff, t_ff;
   logic [61:0]        lcm_ff;
   logic               neg_ff;
   logic [30:0]        dsr_ff;
   logic               rsp_valid_ff;
   logic [2:0]         verdict_ff;
   logic signed [31:0] pinned_ff;
   logic [30:0]        res_out_ff, mod_out_ff;

   logic               div_start, div_busy;
   logic [63:0]        div_x, div_mag, quo;
   logic [30:0]        div_dsr, rem, adj_rem;
   logic [63:0]        quo_signed;

   cbc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_mag),
      .divisor   (div_dsr),
      .busy      (div_busy),
      .quotient  (quo),
      .remainder (rem)
   );

   // operand select for the shared divider
   always_comb begin
      div_start = 1'b1;
      div_x     = '0;
      div_dsr   = r0_ff;
      case (cmd.op)
         OP_DIV_A2: begin
            div_x   = 64'(val_ff);
            div_dsr = mod_ff;
         end
         OP_EU_DIV: begin
            div_x   = {33'd0, r0_ff};
            div_dsr = r1_ff;
         end
         OP_DIV_DIFF: div_x = {33'd0, a2_ff} - {33'd0, agg_res_ff};
         OP_DIV_N1G:  div_x = {33'd0, agg_mod_ff};
         OP_DIV_M2:   div_x = {33'd0, mod_ff};
         OP_DIV_D: begin
            div_x   = 64'(dq_ff);
            div_dsr = m2_ff;
         end
         OP_DIV_INV: begin
            div_x   = 64'(s0_ff);
            div_dsr = m2_ff;
         end
         OP_DIV_T: begin
            div_x   = prod_ff;
            div_dsr = m2_ff;
         end
         OP_DIV_FIN: begin
            div_x   = {33'd0, agg_res_ff} - 64'(low_ff);
            div_dsr = agg_mod_ff;
         end
         default: div_start = 1'b0;
      endcase
      div_mag    = div_x[63] ? (64'd0 - div_x) : div_x;
      adj_rem    = (neg_ff && rem != '0) ? (dsr_ff - rem) : rem;
      quo_signed = neg_ff ? (64'd0 - quo) : quo;
   end

   // bound tightening for the incoming fact
   logic signed [32:0] v33, lo_val, hi_val;
   logic               lo_en, hi_en;

   always_comb begin
      v33    = 33'(req_value);
      lo_en  = 1'b0;
      hi_en  = 1'b0;
      lo_val = v33;
      hi_val = v33;
      case (req_mode)
         MODE_AT_LEAST: lo_en = 1'b1;
         MODE_AT_MOST:  hi_en = 1'b1;
         MODE_GREATER: begin
            lo_en  = 1'b1;
            lo_val = v33 + 33'sd1;
         end
         MODE_LESS: begin
            hi_en  = 1'b1;
            hi_val = v33 - 33'sd1;
         end
         MODE_EQUAL: begin
            lo_en = 1'b1;
            hi_en = 1'b1;
         end
         default: ;
      endcase
   end

   // Euclid step product, lift products and final verdict
   logic [32:0]        s1_abs;
   logic [62:0]        pm;
   logic [61:0]        t_prod, r_prod;
   logic signed [33:0] start_s;
   logic signed [34:0] end_s;
   logic signed [34:0] high35;
   logic               crossed;
   logic [2:0]         verdict;
   logic signed [31:0] pinned;

   always_comb begin
      s1_abs  = s1_ff[32] ? (33'd0 - s1_ff) : s1_ff;
      pm      = quo[30:0] * s1_abs[31:0];
      t_prod  = d_ff * inv_ff;
      r_prod  = agg_mod_ff * t_ff;
      start_s = 34'(low_ff) + $signed({3'b0, adj_rem});
      end_s   = 35'(start_s) + $signed({4'b0, agg_mod_ff});
      high35  = 35'(high_ff);
      crossed = low_ff > high_ff;
      pinned  = '0;
      if (ovf_ff) begin
         verdict = VERDICT_OVERFLOW;
      end else if (clash_ff) begin
         verdict = VERDICT_CLASH;
      end else if (agg_mod_ff == '0) begin
         verdict = VERDICT_NONE;
      end else if (!low_v_ff || !high_v_ff || crossed) begin
         verdict = VERDICT_CONSISTENT;
      end else if (35'(start_s) > high35) begin
         verdict = VERDICT_INFEASIBLE;
      end else if (end_s > high35) begin
         verdict = VERDICT_PINNED;
         pinned  = start_s[31:0];
      end else begin
         verdict = VERDICT_CONSISTENT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         agg_res_ff   <= '0;
         agg_mod_ff   <= '0;
         clash_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         low_ff       <= '0;
         high_ff      <= '0;
         low_v_ff     <= 1'b0;
         high_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
         merge_ff     <= 1'b0;
      end else begin
         if (cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (div_start) begin
            neg_ff <= div_x[63];
            dsr_ff <= div_dsr;
         end
         case (cmd.op)
            OP_LOAD: begin
               val_ff   <= req_value;
               mod_ff   <= req_modulus;
               last_ff  <= req_last;
               merge_ff <= (req_mode == MODE_CONGRUENCE) && (req_modulus != '0)
                           && !clash_ff && !ovf_ff;
               if (lo_en && (!low_v_ff || lo_val > low_ff)) begin
                  low_ff   <= lo_val;
                  low_v_ff <= 1'b1;
               end
               if (hi_en && (!high_v_ff || hi_val < high_ff)) begin
                  high_ff   <= hi_val;
                  high_v_ff <= 1'b1;
               end
            end
            OP_SET_A2: a2_ff <= adj_rem;
            OP_FIRST: begin
               agg_res_ff <= a2_ff;
               agg_mod_ff <= mod_ff;
            end
            OP_EU_INIT: begin
               r0_ff <= agg_mod_ff;
               r1_ff <= mod_ff;
               s0_ff <= 33'sd1;
               s1_ff <= '0;
            end
            OP_EU_MUL: prod_ff <= s1_ff[32] ? (64'd0 - {1'b0, pm}) : {1'b0, pm};
            OP_EU_UPD: begin
               r0_ff <= r1_ff;
               r1_ff <= rem;
               s0_ff <= s1_ff;
               s1_ff <= s0_ff - $signed(prod_ff[32:0]);
            end
            OP_SET_CLASH: clash_ff <= 1'b1;
            OP_SET_DQ:    dq_ff <= quo_signed[32:0];
            OP_SET_N1G:   n1g_ff <= quo[30:0];
            OP_SET_M2:    m2_ff <= quo[30:0];
            OP_LCM_MUL:   lcm_ff <= n1g_ff * mod_ff;
            OP_SET_OVF:   ovf_ff <= 1'b1;
            OP_SET_D:     d_ff <= adj_rem;
            OP_SET_INV:   inv_ff <= adj_rem;
            OP_T_MUL:     prod_ff <= {2'b0, t_prod};
            OP_SET_T:     t_ff <= rem;
            OP_T_ZERO:    t_ff <= '0;
            OP_R_MUL:     prod_ff <= {2'b0, r_prod};
            OP_COMMIT: begin
               agg_res_ff <= agg_res_ff + prod_ff[30:0];
               agg_mod_ff <= lcm_ff[30:0];
            end
            OP_EMIT: begin
               verdict_ff   <= verdict;
               pinned_ff    <= pinned;
               res_out_ff   <= agg_res_ff;
               mod_out_ff   <= agg_mod_ff;
               agg_res_ff   <= '0;
               agg_mod_ff   <= '0;
               clash_ff     <= 1'b0;
               ovf_ff       <= 1'b0;
               low_ff       <= '0;
               high_ff      <= '0;
               low_v_ff     <= 1'b0;
               high_v_ff    <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      status.div_busy   = div_busy;
      status.merge_en   = merge_ff;
      status.last       = last_ff;
      status.agg_empty  = agg_mod_ff == '0;
      status.r1_zero    = r1_ff == '0;
      status.rem_zero   = rem == '0;
      status.lcm_over   = {2'b0, lcm_ff} > MOD_LIMIT;
      status.m2_one     = m2_ff == 31'd1;
      status.need_bound = !ovf_ff && !clash_ff && agg_mod_ff != '0
                          && low_v_ff && high_v_ff && !crossed;
      status.out_full   = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_pinned_value   = pinned_ff;
   assign rsp_merged_residue = res_out_ff;
   assign rsp_merged_modulus = mod_out_ff;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_mod_limit: assert property (@(posedge clock) disable iff (reset)
      {33'd0, agg_mod_ff} <= MOD_LIMIT)
      else $error("merged modulus above limit");

   a_res_range: assert property (@(posedge clock) disable iff (reset)
      (agg_mod_ff != '0) |-> (agg_res_ff < agg_mod_ff))
      else $error("merged residue not reduced");

   a_res_empty: assert property (@(posedge clock) disable iff (reset)
      (agg_mod_ff == '0) |-> (agg_res_ff == '0))
      else $error("residue held without congruence");

endmodule

FILE: hw/rtl/cbc_controller.sv
module cbc_controller
   import cbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE, S_DISPATCH, S_DIV_WAIT, S_GO_A2, S_SET_A2, S_FIRST, S_DONE_ITEM,
      S_EU_INIT, S_EU_TEST, S_GO_EU, S_EU_MUL, S_EU_UPD, S_GO_DIFF, S_CHK_DIFF,
      S_GO_N1G, S_SET_N1G, S_GO_M2, S_SET_M2, S_LCM_MUL, S_CHK_LCM,
      S_GO_D, S_SET_D, S_GO_INV, S_SET_INV, S_T_MUL, S_GO_T, S_SET_T,
      S_R_MUL, S_COMMIT, S_FINISH, S_GO_FIN, S_EMIT
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.merge_en) state_in = S_GO_A2;
            else if (status.last) state_in = S_FINISH;
            else state_in = S_IDLE;
         end
         S_DIV_WAIT: if (!status.div_busy) state_in = ret_ff;
         S_GO_A2: begin
            cmd.op = OP_DIV_A2;   ret_in = S_SET_A2;  state_in = S_DIV_WAIT;
         end
         S_SET_A2: begin
            cmd.op   = OP_SET_A2;
            state_in = status.agg_empty ? S_FIRST : S_EU_INIT;
         end
         S_FIRST: begin
            cmd.op = OP_FIRST;  state_in = S_DONE_ITEM;
         end
         S_DONE_ITEM: state_in = status.last ? S_FINISH : S_IDLE;
         S_EU_INIT: begin
            cmd.op = OP_EU_INIT;  state_in = S_EU_TEST;
         end
         S_EU_TEST: state_in = status.r1_zero ? S_GO_DIFF : S_GO_EU;
         S_GO_EU: begin
            cmd.op = OP_EU_DIV;   ret_in = S_EU_MUL;  state_in = S_DIV_WAIT;
         end
         S_EU_MUL: begin
            cmd.op = OP_EU_MUL;  state_in = S_EU_UPD;
         end
         S_EU_UPD: begin
            cmd.op = OP_EU_UPD;  state_in = S_EU_TEST;
         end
         S_GO_DIFF: begin
            cmd.op = OP_DIV_DIFF; ret_in = S_CHK_DIFF; state_in = S_DIV_WAIT;
         end
         S_CHK_DIFF: begin
            if (status.rem_zero) begin
               cmd.op = OP_SET_DQ;     state_in = S_GO_N1G;
            end else begin
               cmd.op = OP_SET_CLASH;  state_in = S_DONE_ITEM;
            end
         end
         S_GO_N1G: begin
            cmd.op = OP_DIV_N1G;  ret_in = S_SET_N1G; state_in = S_DIV_WAIT;
         end
         S_SET_N1G: begin
            cmd.op = OP_SET_N1G;  state_in = S_GO_M2;
         end
         S_GO_M2: begin
            cmd.op = OP_DIV_M2;   ret_in = S_SET_M2;  state_in = S_DIV_WAIT;
         end
         S_SET_M2: begin
            cmd.op = OP_SET_M2;  state_in = S_LCM_MUL;
         end
         S_LCM_MUL: begin
            cmd.op = OP_LCM_MUL;  state_in = S_CHK_LCM;
         end
         S_CHK_LCM: begin
            if (status.lcm_over) begin
               cmd.op = OP_SET_OVF;  state_in = S_DONE_ITEM;
            end else if (status.m2_one) begin
               cmd.op = OP_T_ZERO;   state_in = S_R_MUL;
            end else begin
               state_in = S_GO_D;
            end
         end
         S_GO_D: begin
            cmd.op = OP_DIV_D;    ret_in = S_SET_D;   state_in = S_DIV_WAIT;
         end
         S_SET_D: begin
            cmd.op = OP_SET_D;  state_in = S_GO_INV;
         end
         S_GO_INV: begin
            cmd.op = OP_DIV_INV;  ret_in = S_SET_INV; state_in = S_DIV_WAIT;
         end
         S_SET_INV: begin
            cmd.op = OP_SET_INV;  state_in = S_T_MUL;
         end
         S_T_MUL: begin
            cmd.op = OP_T_MUL;  state_in = S_GO_T;
         end
         S_GO_T: begin
            cmd.op = OP_DIV_T;    ret_in = S_SET_T;   state_in = S_DIV_WAIT;
         end
         S_SET_T: begin
            cmd.op = OP_SET_T;  state_in = S_R_MUL;
         end
         S_R_MUL: begin
            cmd.op = OP_R_MUL;  state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.op = OP_COMMIT;  state_in = S_DONE_ITEM;
         end
         S_FINISH: state_in = status.need_bound ? S_GO_FIN : S_EMIT;
         S_GO_FIN: begin
            cmd.op = OP_DIV_FIN;  ret_in = S_EMIT;    state_in = S_DIV_WAIT;
         end
         S_EMIT: begin
            if (!status.out_full) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

FILE: hw/rtl/congruence_bound_checker.sv
// channel   direction  ports                                           handshake
// req       in         req_mode req_value req_modulus req_last         req_valid / req_stall
// rsp       out        rsp_verdict rsp_pinned_value                    rsp_valid / rsp_stall
//                      rsp_merged_residue rsp_merged_modulus
//
// One fact at a time; req_stall is high whenever the controller is busy.
// Every division runs in the shared 64-step divider while the controller waits.
// Reset is synchronous and clears all group state. A result waits in the
// output register under rsp_stall while the next facts are taken.
module congruence_bound_checker
   import cbc_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   input  logic [30:0]        req_modulus,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_verdict,
   output logic signed [31:0] rsp_pinned_value,
   output logic [30:0]        rsp_merged_residue,
   output logic [30:0]        rsp_merged_modulus
);

   cmd_type    cmd;
   status_type status;

   // sequence the merge: reduce, extended gcd, solvability, lcm, lift
   cbc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the running congruence and bounds; drive the result transfer
   cbc_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_mode           (req_mode),
      .req_value          (req_value),
      .req_modulus        (req_modulus),
      .req_last           (req_last),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_verdict        (rsp_verdict),
      .rsp_pinned_value   (rsp_pinned_value),
      .rsp_merged_residue (rsp_merged_residue),
      .rsp_merged_modulus (rsp_merged_modulus)
   );

endmodule
